// ----- rtl/slru_pkg.sv -----
package slru_pkg;

   localparam int ADDRESS_W       = 32;
   localparam int HIT_TOTAL_W     = 32;
   localparam int CSR_W           = 4;
   localparam int CSR_INDEX_W     = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS_LOG2      = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_WRITE_ALLOC = 1'd1;

   localparam logic [CSR_W-1:0] WAYS_LOG2_RESET = 4'd2;

   localparam int LINES_DEF       = 512;
   localparam int BLOCK_BYTES_DEF = 32;
   localparam int ADDR_BITS_DEF   = 32;
   localparam int CELLS_DEF       = 8;

endpackage

// ----- rtl/slru_if.sv -----
interface slru_req_if;
   logic                            valid;
   logic                            ready;
   logic [slru_pkg::ADDRESS_W-1:0]  address;
   logic                            is_store;

   modport source (output valid, output address, output is_store, input ready);
   modport sink   (input valid, input address, input is_store, output ready);
endinterface

interface slru_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             hit;
   logic [slru_pkg::HIT_TOTAL_W-1:0] hit_total;

   modport source (output valid, output hit, output hit_total, input ready);
   modport sink   (input valid, input hit, input hit_total, output ready);
endinterface

// ----- rtl/slru_cell.sv -----
module slru_cell #(
   parameter int LINES    = slru_pkg::LINES_DEF,
   parameter int CELLS    = slru_pkg::CELLS_DEF,
   parameter int CELL_IDX = 0,
   parameter int TAG_W    = 27,
   parameter type acc_type = logic,
   parameter type ctl_type = logic,
   localparam int LINE_W  = $clog2(LINES),
   localparam int CL      = $clog2(CELLS),
   localparam int ROW_W   = LINE_W - CL,
   localparam int ROWS    = LINES / CELLS
) (
   input  logic             clock,
   input  ctl_type          ctl,
   input  acc_type          acc_in,
   output acc_type          acc_out,
   input  logic             rd_en,
   input  logic [ROW_W-1:0] rd_row,
   input  logic [ROW_W-1:0] data_row,
   input  logic             wr_en,
   input  logic [ROW_W-1:0] wr_row
);

   typedef struct packed {
      logic              valid;
      logic [TAG_W-1:0]  tag;
      logic [LINE_W-1:0] rank;
   } entry_type;

   entry_type         mem [ROWS];
   entry_type         rd_ff;
   entry_type         wr_in;
   logic [LINE_W-1:0] line;
   logic [LINE_W-1:0] way;
   logic              in_set;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_row];
      end
      if (wr_en) begin
         mem[wr_row] <= wr_in;
      end
   end

   assign line   = {data_row, CL'(CELL_IDX)};
   assign in_set = ((line >> ctl.wl) == ctl.set_hi);
   assign way    = line & ctl.ways_m1;

   // search: keep the lowest-numbered match, invalid way and oldest way
   always_comb begin
      acc_out = acc_in;
      if (in_set) begin
         if (rd_ff.valid && rd_ff.tag == ctl.blk && !acc_in.hit_found) begin
            acc_out.hit_found = 1'b1;
            acc_out.hit_way   = way;
            acc_out.hit_rank  = rd_ff.rank;
         end
         if (!rd_ff.valid && !acc_in.inv_found) begin
            acc_out.inv_found = 1'b1;
            acc_out.inv_way   = way;
         end
         if (!acc_in.max_found || rd_ff.rank > acc_in.max_rank) begin
            acc_out.max_found = 1'b1;
            acc_out.max_way   = way;
            acc_out.max_rank  = rd_ff.rank;
         end
      end
   end

   // update: zero the entry while clearing; else age the set, then make the used way most recent
   always_comb begin
      wr_in = rd_ff;
      if (ctl.clear) begin
         wr_in = '0;
      end else if (in_set) begin
         if (rd_ff.valid && {1'b0, rd_ff.rank} < ctl.limit && rd_ff.rank < ctl.ways_m1) begin
            wr_in.rank = rd_ff.rank + 1'b1;
         end
         if (way == ctl.used) begin
            wr_in.rank = '0;
            if (ctl.wtag) begin
               wr_in.valid = 1'b1;
               wr_in.tag   = ctl.blk;
            end
         end
      end
   end

endmodule

// ----- rtl/set_associative_lru_cache.sv -----
// channel | dir | payload                 | handshake
// req_ch  | in  | address, is_store       | valid/ready
// rsp_ch  | out | hit, hit_total          | valid/ready
// csr_*   | in  | csr_index, csr_wdata    | csr_we, no wait
//
// one request at a time; a lookup reads one row of CELLS ways per cycle from the
// cell banks, in a search pass and then an update pass over the rows of the set.
// after reset a clearing pass over all LINES / CELLS rows (64 by default) zeroes the
// valid bits before the first request is taken.
// a stalled response holds in the output register; the next request is taken
// meanwhile and waits at its end for the register to free up.
module set_associative_lru_cache #(
   parameter int LINES       = slru_pkg::LINES_DEF,
   parameter int BLOCK_BYTES = slru_pkg::BLOCK_BYTES_DEF,
   parameter int ADDR_BITS   = slru_pkg::ADDR_BITS_DEF,
   parameter int CELLS       = slru_pkg::CELLS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   slru_req_if.sink                          req_ch,
   slru_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [slru_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [slru_pkg::CSR_W-1:0]        csr_wdata
);

   localparam int LINE_W = $clog2(LINES);
   localparam int CL     = $clog2(CELLS);
   localparam int ROW_W  = LINE_W - CL;
   localparam int ROWS   = LINES / CELLS;
   localparam int OFF_W  = $clog2(BLOCK_BYTES);
   localparam int TAG_W  = slru_pkg::ADDRESS_W - OFF_W;
   localparam logic [slru_pkg::ADDRESS_W-1:0] ADDR_MASK =
      (ADDR_BITS >= slru_pkg::ADDRESS_W) ? '1 :
      slru_pkg::ADDRESS_W'((64'd1 << ADDR_BITS) - 64'd1);

   typedef struct packed {
      logic              hit_found;
      logic [LINE_W-1:0] hit_way;
      logic [LINE_W-1:0] hit_rank;
      logic              inv_found;
      logic [LINE_W-1:0] inv_way;
      logic              max_found;
      logic [LINE_W-1:0] max_way;
      logic [LINE_W-1:0] max_rank;
   } acc_type;

   typedef struct packed {
      logic [slru_pkg::CSR_W-1:0] wl;
      logic [LINE_W-1:0]          set_hi;
      logic [LINE_W-1:0]          ways_m1;
      logic [TAG_W-1:0]           blk;
      logic [LINE_W-1:0]          used;
      logic [LINE_W:0]            limit;
      logic                       wtag;
      logic                       clear;
   } ctl_type;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_SEARCH = 6'b000100,
      ST_DECIDE = 6'b001000,
      ST_UPDATE = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type                  state_ff, state_in;
   logic [slru_pkg::CSR_W-1:0] cfg_wl_ff;
   logic                       cfg_nwa_ff;

   logic [TAG_W-1:0]           blk_ff, blk_in;
   logic                       store_ff, store_in;
   logic [slru_pkg::CSR_W-1:0] wl_ff, wl_in;
   logic [LINE_W-1:0]          set_ff, set_in;
   logic [LINE_W-1:0]          ways_m1_ff, ways_m1_in;
   logic [ROW_W-1:0]           start_ff, start_in;
   logic [ROW_W:0]             count_ff, count_in;
   logic [ROW_W-1:0]           issue_row_ff, issue_row_in;
   logic [ROW_W:0]             issue_left_ff, issue_left_in;
   logic                       data_v_ff, data_v_in;
   logic [ROW_W-1:0]           data_row_ff, data_row_in;
   logic [ROW_W-1:0]           clr_row_ff, clr_row_in;
   acc_type                    acc_ff, acc_in;
   logic [LINE_W-1:0]          used_ff, used_in;
   logic [LINE_W:0]            limit_ff, limit_in;
   logic                       wtag_ff, wtag_in;
   logic                       hit_ff, hit_in;
   logic [slru_pkg::HIT_TOTAL_W-1:0] hits_ff, hits_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_hit_ff, rsp_hit_in;
   logic [slru_pkg::HIT_TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   logic [slru_pkg::CSR_W-1:0]     wl_eff;
   logic [slru_pkg::ADDRESS_W-1:0] addr_m;
   logic [TAG_W-1:0]               blk_new;
   logic [LINE_W-1:0]              blk_low, sets_m1, set_new, base_new, ways_m1_new;
   logic                           rd_en, wr_en;
   logic [ROW_W-1:0]               wr_row;
   ctl_type                        ctl;
   acc_type                        chain [CELLS+1];

   // geometry of the current configuration
   always_comb begin
      wl_eff      = (cfg_wl_ff > slru_pkg::CSR_W'(LINE_W)) ? slru_pkg::CSR_W'(LINE_W)
                                                          : cfg_wl_ff;
      addr_m      = req_ch.address & ADDR_MASK;
      blk_new     = TAG_W'(addr_m >> OFF_W);
      blk_low     = LINE_W'(blk_new);
      sets_m1     = LINE_W'((LINES >> wl_eff) - 1);
      set_new     = blk_low & sets_m1;
      base_new    = LINE_W'(set_new << wl_eff);
      ways_m1_new = LINE_W'(({{LINE_W{1'b0}}, 1'b1} << wl_eff) - 1'b1);
   end

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.hit       = rsp_hit_ff;
   assign rsp_ch.hit_total = rsp_total_ff;

   always_comb begin
      state_in      = state_ff;
      blk_in        = blk_ff;
      store_in      = store_ff;
      wl_in         = wl_ff;
      set_in        = set_ff;
      ways_m1_in    = ways_m1_ff;
      start_in      = start_ff;
      count_in      = count_ff;
      issue_row_in  = issue_row_ff;
      issue_left_in = issue_left_ff;
      data_v_in     = 1'b0;
      data_row_in   = data_row_ff;
      clr_row_in    = clr_row_ff;
      acc_in        = acc_ff;
      used_in       = used_ff;
      limit_in      = limit_ff;
      wtag_in       = wtag_ff;
      hit_in        = hit_ff;
      hits_in       = hits_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_total_in  = rsp_total_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_row        = data_row_ff;

      // row reads shared by the search and update passes
      if (state_ff == ST_SEARCH || state_ff == ST_UPDATE) begin
         if (issue_left_ff != '0) begin
            rd_en         = 1'b1;
            issue_row_in  = issue_row_ff + 1'b1;
            issue_left_in = issue_left_ff - 1'b1;
            data_v_in     = 1'b1;
            data_row_in   = issue_row_ff;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_row     = clr_row_ff;
            clr_row_in = clr_row_ff + 1'b1;
            if (clr_row_ff == ROW_W'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               blk_in        = blk_new;
               store_in      = req_ch.is_store;
               wl_in         = wl_eff;
               set_in        = set_new;
               ways_m1_in    = ways_m1_new;
               start_in      = ROW_W'(base_new >> CL);
               count_in      = (wl_eff >= slru_pkg::CSR_W'(CL))
                               ? ((ROW_W+1)'(1) << (wl_eff - slru_pkg::CSR_W'(CL)))
                               : (ROW_W+1)'(1);
               issue_row_in  = ROW_W'(base_new >> CL);
               issue_left_in = count_in;
               acc_in        = '0;
               state_in      = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (data_v_ff) begin
               acc_in = chain[CELLS];
            end
            if (issue_left_ff == '0 && !data_v_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            hit_in        = acc_ff.hit_found;
            issue_row_in  = start_ff;
            issue_left_in = count_ff;
            state_in      = ST_UPDATE;
            if (acc_ff.hit_found) begin
               used_in  = acc_ff.hit_way;
               limit_in = {1'b0, acc_ff.hit_rank};
               wtag_in  = 1'b0;
               if (hits_ff != '1) begin
                  hits_in = hits_ff + 1'b1;
               end
            end else if (store_ff && cfg_nwa_ff) begin
               state_in = ST_DONE;
            end else if (acc_ff.inv_found) begin
               used_in  = acc_ff.inv_way;
               limit_in = {1'b1, {LINE_W{1'b0}}};
               wtag_in  = 1'b1;
            end else begin
               used_in  = acc_ff.max_way;
               limit_in = {1'b0, acc_ff.max_rank};
               wtag_in  = 1'b1;
            end
         end
         ST_UPDATE: begin
            wr_en = data_v_ff;
            if (issue_left_ff == '0 && !data_v_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_total_in = hits_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl.wl      = wl_ff;
      ctl.set_hi  = set_ff;
      ctl.ways_m1 = ways_m1_ff;
      ctl.blk     = blk_ff;
      ctl.used    = used_ff;
      ctl.limit   = limit_ff;
      ctl.wtag    = wtag_ff;
      ctl.clear   = (state_ff == ST_CLEAR);
   end

   assign chain[0] = acc_ff;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      slru_cell #(
         .LINES    (LINES),
         .CELLS    (CELLS),
         .CELL_IDX (i),
         .TAG_W    (TAG_W),
         .acc_type (acc_type),
         .ctl_type (ctl_type)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .acc_in   (chain[i]),
         .acc_out  (chain[i+1]),
         .rd_en    (rd_en),
         .rd_row   (issue_row_ff),
         .data_row (data_row_ff),
         .wr_en    (wr_en),
         .wr_row   (wr_row)
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cfg_wl_ff     <= slru_pkg::WAYS_LOG2_RESET;
         cfg_nwa_ff    <= 1'b0;
         issue_left_ff <= '0;
         data_v_ff     <= 1'b0;
         clr_row_ff    <= '0;
         hits_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_left_ff <= issue_left_in;
         data_v_ff     <= data_v_in;
         clr_row_ff    <= clr_row_in;
         hits_ff       <= hits_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               slru_pkg::CSR_WAYS_LOG2:      cfg_wl_ff  <= csr_wdata;
               slru_pkg::CSR_NO_WRITE_ALLOC: cfg_nwa_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      blk_ff       <= blk_in;
      store_ff     <= store_in;
      wl_ff        <= wl_in;
      set_ff       <= set_in;
      ways_m1_ff   <= ways_m1_in;
      start_ff     <= start_in;
      count_ff     <= count_in;
      issue_row_ff <= issue_row_in;
      data_row_ff  <= data_row_in;
      acc_ff       <= acc_in;
      used_ff      <= used_in;
      limit_ff     <= limit_in;
      wtag_ff      <= wtag_in;
      hit_ff       <= hit_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_total_ff <= rsp_total_in;
   end

   // a response only appears at the end of a request
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

   // the hit counter never goes backwards
   a_hits_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> hits_ff >= $past(hits_ff))
      else $error("hit counter decreased");

   // a pass never reads more rows than the banks hold
   a_rows_bounded: assert property (@(posedge clock) disable iff (reset)
      issue_left_ff <= (ROW_W+1)'(ROWS))
      else $error("row count out of range");

endmodule

// ----- bench/testbench.sv -----
module testbench;

   localparam int N_LINES   = 512;
   localparam int RANDOM_N  = 1620;
   localparam int LIMIT     = 1200000;

   typedef struct packed {
      logic        hit;
      logic [31:0] hit_total;
   } lookup_type;

   typedef struct {
      logic [31:0] address;
      logic        is_store;
      logic        known;
      logic        hit;
      logic [31:0] hit_total;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [slru_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [slru_pkg::CSR_W-1:0] csr_wdata;

   slru_req_if req_ch ();
   slru_rsp_if rsp_ch ();

   set_associative_lru_cache u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow tag store
   logic        tag_valid [N_LINES];
   logic [26:0] tag_block [N_LINES];
   int unsigned tag_rank [N_LINES];
   logic [31:0] hit_count;
   logic [3:0]  ways_log2_sh;
   logic        no_alloc_sh;

   lookup_type expected_q[$];
   int errors = 0;
   int accepted = 0;
   bit quiet = 0;
   bit held_off = 0;
   longint cycles = 0;
   logic [26:0] hot_blocks [24];

   function automatic void age_set(int base, int ways, int used, int unsigned limit);
      for (int w = 0; w < ways; w++) begin
         if (tag_valid[base+w] && tag_rank[base+w] < limit && tag_rank[base+w] < ways - 1)
            tag_rank[base+w]++;
      end
      tag_rank[base+used] = 0;
   endfunction

   function automatic lookup_type lookup(logic [31:0] address, logic is_store);
      int ways, sets, base, victim;
      int unsigned best;
      logic [26:0] blk;
      bit found, filled;
      lookup_type r;
      ways = (ways_log2_sh > 9) ? N_LINES : (1 << ways_log2_sh);
      sets = N_LINES / ways;
      blk = address[31:5];
      base = int'(blk % sets) * ways;
      found = 0;
      for (int w = 0; w < ways; w++) begin
         if (!found && tag_valid[base+w] && tag_block[base+w] == blk) begin
            found = 1;
            age_set(base, ways, w, tag_rank[base+w]);
         end
      end
      if (found) begin
         if (hit_count != 32'hFFFF_FFFF) hit_count++;
      end else if (!(is_store && no_alloc_sh)) begin
         filled = 0;
         for (int w = 0; w < ways; w++) begin
            if (!filled && !tag_valid[base+w]) begin
               age_set(base, ways, w, 32'hFFFF_FFFF);
               tag_valid[base+w] = 1'b1;
               tag_block[base+w] = blk;
               tag_rank[base+w] = 0;
               filled = 1;
            end
         end
         if (!filled) begin
            victim = 0;
            best = tag_rank[base];
            for (int w = 1; w < ways; w++) begin
               if (tag_rank[base+w] > best) begin
                  best = tag_rank[base+w];
                  victim = w;
               end
            end
            age_set(base, ways, victim, best);
            tag_block[base+victim] = blk;
         end
      end
      r.hit = found;
      r.hit_total = hit_count;
      return r;
   endfunction

   task automatic send(logic [31:0] address, logic is_store, stim_row_type row);
      int gap;
      lookup_type r;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.address <= address;
      req_ch.is_store <= is_store;
      do @(posedge clock); while (!req_ch.ready);
      r = lookup(address, is_store);
      if (row.known) begin
         r.hit = row.hit;
         r.hit_total = row.hit_total;
      end
      expected_q.push_back(r);
      accepted++;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(logic [slru_pkg::CSR_INDEX_W-1:0] index,
                            logic [slru_pkg::CSR_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (index == slru_pkg::CSR_WAYS_LOG2) ways_log2_sh = data;
      else no_alloc_sh = data[0];
   endtask

   function automatic logic [31:0] random_address();
      logic [26:0] blk;
      if ($urandom_range(0, 9) < 7) blk = hot_blocks[$urandom_range(0, 23)];
      else blk = 27'($urandom);
      return {blk, 5'($urandom)};
   endfunction

   task automatic refresh_hot(bit all);
      for (int i = 0; i < 24; i++) begin
         if (i == 0 && (all || $urandom_range(0, 1))) hot_blocks[0] = 27'($urandom);
         else if (i < 12 && (all || $urandom_range(0, 1))) hot_blocks[i] = 27'($urandom);
         else if (i >= 12) hot_blocks[i] = hot_blocks[0] + 27'(i * N_LINES);
      end
   endtask

   // directed: default geometry of 4 ways and 128 sets
   stim_row_type directed [14] = '{
      '{32'h0000_0000, 1'b0, 1'b1, 1'b0, 32'd0},
      '{32'h0000_001F, 1'b1, 1'b1, 1'b1, 32'd1},
      '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 32'd1},
      '{32'hFFFF_FFE0, 1'b1, 1'b1, 1'b1, 32'd2},
      '{32'h0000_1000, 1'b0, 1'b0, 1'b0, 32'd0},
      '{32'h0000_2000, 1'b1, 1'b0, 1'b0, 32'd0},
      '{32'h0000_3000, 1'b0, 1'b0, 1'b0, 32'd0},
      '{32'h0000_1004, 1'b0, 1'b0, 1'b0, 32'd0},
      '{32'h0000_4000, 1'b0, 1'b0, 1'b0, 32'd0},
      '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'd0},
      '{32'h0000_3000, 1'b1, 1'b0, 1'b0, 32'd0},
      '{32'h0000_2000, 1'b0, 1'b0, 1'b0, 32'd0},
      '{32'h8000_0000, 1'b1, 1'b0, 1'b0, 32'd0},
      '{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 32'd0}
   };

   logic [3:0] phase_ways [10] = '{4'd0, 4'd9, 4'd15, 4'd3, 4'd10, 4'd1, 4'd5, 4'd2, 4'd7, 4'd0};
   logic       phase_nwa  [10] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

   initial begin
      stim_row_type none;
      int per_phase;
      none = '{32'd0, 1'b0, 1'b0, 1'b0, 32'd0};
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= slru_pkg::CSR_WAYS_LOG2;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.address <= '0;
      req_ch.is_store <= 1'b0;
      for (int i = 0; i < N_LINES; i++) begin
         tag_valid[i] = 1'b0;
         tag_block[i] = '0;
         tag_rank[i] = 0;
      end
      hit_count = '0;
      ways_log2_sh = slru_pkg::WAYS_LOG2_RESET;
      no_alloc_sh = 1'b0;
      refresh_hot(1);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send(directed[i].address, directed[i].is_store, directed[i]);

      per_phase = RANDOM_N / 10;
      for (int p = 0; p < 10; p++) begin
         settle();
         write_csr(slru_pkg::CSR_WAYS_LOG2, phase_ways[p]);
         write_csr(slru_pkg::CSR_NO_WRITE_ALLOC, {3'd0, phase_nwa[p]});
         refresh_hot(0);
         if (p == 9) quiet = 1;
         for (int i = 0; i < per_phase; i++) send(random_address(), 1'($urandom), none);
      end

      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   // response side backpressure, with one long hold-off to fill the block up
   initial begin
      int n;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (!held_off && accepted >= 300) begin
            held_off = 1;
            rsp_ch.ready <= 1'b0;
            repeat (600) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 16);
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            n = $urandom_range(1, 24);
            rsp_ch.ready <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      lookup_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_ch.hit !== e.hit) begin
               $error("hit: expected %0d, got %0d", e.hit, rsp_ch.hit);
               errors++;
            end
            if (rsp_ch.hit_total !== e.hit_total) begin
               $error("hit_total: expected %0d, got %0d", e.hit_total, rsp_ch.hit_total);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

endmodule
